// ----- design/rc4ks_pkg.sv -----
// shared types and constants for the rc4 keystream cipher
package rc4ks_pkg;

  // longest key held in the key store
  localparam int KEY_MAX_BYTES = 256;
  localparam logic [8:0] KEY_LIMIT = 9'(KEY_MAX_BYTES);

  // input modes
  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_MSG = 1'b1;

  // one input item
  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
    logic       first;
  } rc4ks_req_t;

  // one result item from the engine
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rc4ks_res_t;

  // engine sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_SW1,
    ST_KS_SW2,
    ST_G_RD_I,
    ST_G_RD_J,
    ST_G_SW1,
    ST_G_SW2,
    ST_G_OUT
  } rc4ks_state_t;

endpackage

// ----- design/rc4ks_engine.sv -----
// rc4 engine: key store, permutation memory and the schedule / generator sequencer
module rc4ks_engine import rc4ks_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  rc4ks_req_t req,
  output rc4ks_res_t res,
  input  logic       res_ready
);

  rc4ks_state_t state, state_next;

  // memories
  logic [7:0] perm_mem [256];
  logic [7:0] key_mem [256];
  logic [7:0] perm_rd;
  logic [7:0] key_rd;

  // control registers
  logic [8:0] key_count;
  logic       scheduled;
  logic [7:0] n, kidx, index_i, index_j, si, sj, msg_val;
  logic       fwd;

  // permutation memory port controls
  logic [7:0] perm_raddr;
  logic       perm_we;
  logic [7:0] perm_waddr, perm_wdata;

  logic [7:0] kb, j_ksa, j_gen, t_addr, ks;
  logic [8:0] count_eff;
  logic       key_wr;

  assign kb     = (key_count == '0) ? 8'd0 : key_rd;
  assign j_ksa  = index_j + perm_rd + kb;
  assign j_gen  = index_j + perm_rd;
  assign t_addr = si + sj;
  assign ks     = fwd ? si : perm_rd;

  // key byte write at transfer
  assign count_eff = req.first ? 9'd0 : key_count;
  assign key_wr    = (state == ST_IDLE) && req_valid && (req.mode == MODE_KEY)
                     && (count_eff < KEY_LIMIT);

  // sequencer next state and memory controls
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    res.valid  = 1'b0;
    res.data   = ks ^ msg_val;
    perm_raddr = t_addr;
    perm_we    = 1'b0;
    perm_waddr = n;
    perm_wdata = n;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && req.mode == MODE_MSG) begin
          state_next = (req.first || !scheduled) ? ST_INIT : ST_G_RD_I;
        end
      end
      ST_INIT: begin
        perm_we = 1'b1;
        if (n == 8'hFF) state_next = ST_KS_RD;
      end
      ST_KS_RD: begin
        perm_raddr = n;
        state_next = ST_KS_J;
      end
      ST_KS_J: begin
        perm_raddr = j_ksa;
        state_next = ST_KS_SW1;
      end
      ST_KS_SW1: begin
        perm_we    = 1'b1;
        perm_waddr = n;
        perm_wdata = perm_rd;
        state_next = ST_KS_SW2;
      end
      ST_KS_SW2: begin
        perm_we    = 1'b1;
        perm_waddr = index_j;
        perm_wdata = si;
        state_next = (n == 8'hFF) ? ST_G_RD_I : ST_KS_RD;
      end
      ST_G_RD_I: begin
        perm_raddr = index_i + 8'd1;
        state_next = ST_G_RD_J;
      end
      ST_G_RD_J: begin
        perm_raddr = j_gen;
        state_next = ST_G_SW1;
      end
      ST_G_SW1: begin
        perm_we    = 1'b1;
        perm_waddr = index_i;
        perm_wdata = perm_rd;
        state_next = ST_G_SW2;
      end
      ST_G_SW2: begin
        perm_we    = 1'b1;
        perm_waddr = index_j;
        perm_wdata = si;
        state_next = ST_G_OUT;
      end
      ST_G_OUT: begin
        res.valid = 1'b1;
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (perm_we) perm_mem[perm_waddr] <= perm_wdata;
    perm_rd <= perm_mem[perm_raddr];
  end

  always_ff @(posedge clk) begin
    if (key_wr) key_mem[count_eff[7:0]] <= req.byte_value;
    key_rd <= key_mem[kidx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      scheduled <= 1'b0;
      index_i   <= '0;
      index_j   <= '0;
      n         <= '0;
      kidx      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid && req.mode == MODE_KEY) begin
            if (key_wr) key_count <= count_eff + 9'd1;
            else key_count <= count_eff;
          end
          n    <= '0;
          kidx <= '0;
          if (req_valid && req.mode == MODE_MSG && (req.first || !scheduled)) begin
            index_j <= '0;
          end
        end
        ST_INIT: n <= n + 8'd1;
        ST_KS_J: begin
          index_j <= j_ksa;
          if (key_count == '0 || ({1'b0, kidx} + 9'd1) == key_count) kidx <= '0;
          else kidx <= kidx + 8'd1;
        end
        ST_KS_SW2: begin
          n <= n + 8'd1;
          if (n == 8'hFF) begin
            index_i   <= '0;
            index_j   <= '0;
            scheduled <= 1'b1;
          end
        end
        ST_G_RD_I: index_i <= index_i + 8'd1;
        ST_G_RD_J: index_j <= j_gen;
        default: ;
      endcase
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) msg_val <= req.byte_value;
    if (state == ST_KS_J || state == ST_G_RD_J) si <= perm_rd;
    if (state == ST_G_SW1) sj <= perm_rd;
    // the keystream read and the second swap write share a cycle
    if (state == ST_G_SW2) fwd <= (t_addr == index_j);
  end

endmodule

// ----- design/rc4_keystream_cipher_core.sv -----
// top level of the rc4 keystream cipher with its output register
//
// Input channel (in_valid / in_ready) carries mode, byte_value and first.
// mode 0 loads a key byte into the key store (first restarts the key);
// key bytes past the store limit are dropped. A key byte gives no result.
// mode 1 is a message byte: it gives one out_byte, the byte XORed with
// the next keystream byte.
// A message byte steps through the four accesses (read s[i], read s[j], two
// swap writes plus the s[t] read) of the permutation memory, which has one
// read and one write port. A message byte carrying first, or the first one
// after reset, first runs the key schedule: it fills the permutation, then
// takes 256 swap steps over the key.
// One item is in work at a time; in_ready is high only when idle.
// Results sit in an output register, so the next item is taken while a
// result waits; a stalled receiver holds the engine at its result step.
// Reset clears the key length, the indices and the scheduled flag; the
// memories are not cleared.
module rc4_keystream_cipher_core import rc4ks_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] byte_value,
  input  logic       first,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);

  rc4ks_req_t req;
  rc4ks_res_t res;
  logic       res_ready;

  assign req.mode       = mode;
  assign req.byte_value = byte_value;
  assign req.first      = first;

  rc4ks_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (req),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register takes a result when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) out_byte <= res.data;
  end

endmodule

// ----- tb/sv/rc4_keystream_cipher_core_tb.sv -----
// testbench for the rc4 keystream cipher core: directed vectors, then random keyed traffic
module rc4_keystream_cipher_core_tb;
  import rc4ks_pkg::*;

  localparam int ITEMS      = 1900;
  localparam int IDLE_PCT   = 31;
  localparam int HOLD_LEN   = 400;
  localparam int WATCH_MAX  = 10000;
  localparam int DRAIN_WAIT = 50;

  // one directed row; want is used only when typed is set
  typedef struct packed {
    logic       m;
    logic [7:0] v;
    logic       f;
    logic       typed;
    logic [7:0] want;
  } vec_row_t;

  // empty key after reset, the "Key"/"Plaintext" vector, key loaded after
  // schedule, and a single zero key byte
  localparam vec_row_t DIRECTED [21] = '{
    '{MODE_MSG, 8'h00, 1'b0, 1'b0, 8'h00},
    '{MODE_MSG, 8'hff, 1'b0, 1'b0, 8'h00},
    '{MODE_KEY, 8'h4b, 1'b1, 1'b0, 8'h00},
    '{MODE_KEY, 8'h65, 1'b0, 1'b0, 8'h00},
    '{MODE_KEY, 8'h79, 1'b0, 1'b0, 8'h00},
    '{MODE_MSG, 8'h50, 1'b1, 1'b1, 8'hbb},
    '{MODE_MSG, 8'h6c, 1'b0, 1'b1, 8'hf3},
    '{MODE_MSG, 8'h61, 1'b0, 1'b1, 8'h16},
    '{MODE_MSG, 8'h69, 1'b0, 1'b1, 8'he8},
    '{MODE_MSG, 8'h6e, 1'b0, 1'b1, 8'hd9},
    '{MODE_MSG, 8'h74, 1'b0, 1'b1, 8'h40},
    '{MODE_MSG, 8'h65, 1'b0, 1'b1, 8'haf},
    '{MODE_MSG, 8'h78, 1'b0, 1'b1, 8'h0a},
    '{MODE_MSG, 8'h74, 1'b0, 1'b1, 8'hd3},
    '{MODE_KEY, 8'hff, 1'b1, 1'b0, 8'h00},
    '{MODE_KEY, 8'h00, 1'b0, 1'b0, 8'h00},
    '{MODE_MSG, 8'h5a, 1'b0, 1'b0, 8'h00},
    '{MODE_MSG, 8'hff, 1'b1, 1'b0, 8'h00},
    '{MODE_MSG, 8'h00, 1'b0, 1'b0, 8'h00},
    '{MODE_KEY, 8'h00, 1'b1, 1'b0, 8'h00},
    '{MODE_MSG, 8'ha5, 1'b1, 1'b0, 8'h00}
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       mode;
  logic [7:0] byte_value;
  logic       first;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;

  // predictor state
  logic [7:0]  sbox [256];
  logic [7:0]  key_bytes [256];
  int unsigned key_len;
  logic [7:0]  gen_i;
  logic [7:0]  gen_j;
  bit          keyed;

  logic [7:0] out_bytes_due [$];
  logic [7:0] due_byte;
  bit         failed;
  bit         calm;
  bit         hold_req;
  bit         hold_done;
  int         loaded;
  int         idle_cycles;
  int         hold_left;

  rc4_keystream_cipher_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .byte_value (byte_value),
    .first      (first),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // key schedule: identity permutation, then 256 swap steps over the key
  function automatic void key_schedule();
    logic [7:0] acc;
    logic [7:0] kb;
    logic [7:0] t;
    int         n;
    acc = 8'h00;
    for (n = 0; n < 256; n++) sbox[n] = 8'(n);
    for (n = 0; n < 256; n++) begin
      kb = (key_len != 0) ? key_bytes[n % key_len] : 8'h00;
      acc = acc + sbox[n] + kb;
      t = sbox[n];
      sbox[n] = sbox[acc];
      sbox[acc] = t;
    end
    gen_i = 8'h00;
    gen_j = 8'h00;
    keyed = 1'b1;
  endfunction

  // one item through the cipher; has_out tells whether a byte comes out
  function automatic void cipher_step(input logic m, input logic [7:0] v, input logic f,
                                      output logic has_out, output logic [7:0] res);
    logic [7:0] t;
    has_out = 1'b0;
    res = 8'h00;
    if (m == MODE_KEY) begin
      if (f) key_len = 0;
      // bytes past the store limit are dropped
      if (key_len < KEY_MAX_BYTES) begin
        key_bytes[key_len] = v;
        key_len++;
      end
    end else begin
      if (f || !keyed) key_schedule();
      gen_i = gen_i + 8'd1;
      gen_j = gen_j + sbox[gen_i];
      t = sbox[gen_i];
      sbox[gen_i] = sbox[gen_j];
      sbox[gen_j] = t;
      res = v ^ sbox[8'(sbox[gen_i] + sbox[gen_j])];
      has_out = 1'b1;
    end
  endfunction

  // offer one item at the falling edge and hold it until the transfer
  task automatic send_item(input logic m, input logic [7:0] v, input logic f,
                           input logic typed, input logic [7:0] want);
    logic       has_out;
    logic [7:0] res;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    if (!(m == MODE_KEY && !f && key_len >= KEY_MAX_BYTES)) loaded++;
    in_valid   <= 1'b1;
    mode       <= m;
    byte_value <= v;
    first      <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cipher_step(m, v, f, has_out, res);
    if (has_out) out_bytes_due = {out_bytes_due, (typed ? want : res)};
    @(negedge clk);
  endtask

  // result side: compare each transfer with the oldest expected byte
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (out_bytes_due.size() == 0) begin
        $error("out_byte: unexpected result %02h", out_byte);
        failed = 1'b1;
      end else begin
        due_byte = out_bytes_due.pop_front();
        if (out_byte !== due_byte) begin
          $error("out_byte: expected %02h, got %02h", due_byte, out_byte);
          failed = 1'b1;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, and a calm stretch
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCH_MAX) begin
        $display("rc4_keystream_cipher_core_tb: FAIL");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int          k;
    int          klen;
    int          mlen;
    int          seq;
    int          pick;
    logic        m;
    logic        f;
    rst        = 1'b1;
    in_valid   = 1'b0;
    mode       = MODE_KEY;
    byte_value = 8'h00;
    first      = 1'b0;
    failed     = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    loaded     = 0;
    key_len    = 0;
    gen_i      = 8'h00;
    gen_j      = 8'h00;
    keyed      = 1'b0;
    seq        = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    for (k = 0; k < $size(DIRECTED); k++) begin
      send_item(DIRECTED[k].m, DIRECTED[k].v, DIRECTED[k].f,
                DIRECTED[k].typed, DIRECTED[k].want);
    end

    // random traffic: mostly a key then a run of message bytes, some loose items
    while (loaded < ITEMS) begin
      calm = (loaded >= 900 && loaded < 1200);
      if (loaded >= 300 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75 || seq == 2) begin
        // an over-long key is forced once, and appears now and then
        if (seq == 2) klen = $urandom_range(257, 300);
        else if ($urandom_range(0, 99) < 3) klen = $urandom_range(250, 300);
        else klen = $urandom_range(1, 16);
        for (k = 0; k < klen; k++) send_item(MODE_KEY, 8'($urandom), k == 0, 1'b0, 8'h00);
        mlen = $urandom_range(5, 40);
        for (k = 0; k < mlen; k++) send_item(MODE_MSG, 8'($urandom), k == 0, 1'b0, 8'h00);
      end else begin
        // loose items; a schedule rerun is kept rare since it is slow
        repeat ($urandom_range(1, 8)) begin
          m = ($urandom_range(0, 1) == 0) ? MODE_KEY : MODE_MSG;
          if (m == MODE_KEY) f = ($urandom_range(0, 3) == 0);
          else f = ($urandom_range(0, 19) == 0);
          send_item(m, 8'($urandom), f, 1'b0, 8'h00);
        end
      end
      seq++;
    end
    in_valid  <= 1'b0;
    calm      = 1'b0;

    // drain, then give a stray result time to show up
    while (out_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed) begin
      $display("rc4_keystream_cipher_core_tb: PASS");
    end else begin
      $display("rc4_keystream_cipher_core_tb: FAIL");
    end
    $finish;
  end

endmodule
